// ----- hdl/lzwd_pkg.sv -----
// shared types and constants for the 12-bit lzw decoder
`default_nettype none

package lzwd_pkg;

  localparam int unsigned CODE_W    = 12;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OUT_DEPTH = 64;
  localparam int unsigned OUT_AW    = 6;
  localparam int unsigned OUT_CW    = 7;

  localparam logic [CODE_W-1:0] PAD_CODE  = 12'hFFF;
  localparam logic [CODE_W-1:0] LIT_LIMIT = 12'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CODE,
    ST_WALK,
    ST_COPY,
    ST_UPDATE,
    ST_NEXT,
    ST_EMIT
  } lzwd_state_e;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_LOAD
  } lzwd_emit_e;

  typedef struct packed {
    logic              wr_en;
    logic [OUT_AW-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              start;
    logic [OUT_CW-1:0] count;
    logic              err;
  } lzwd_obuf_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/lzwd_obuf.sv -----
// output byte buffer with emit sequencer and output register
`default_nettype none

module lzwd_obuf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lzwd_pkg::lzwd_obuf_ctrl_t ctrl_i,
  output logic                    busy_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              byte_out_o,
  output logic                    last_of_run_o,
  output logic                    error_flag_o
);
  import lzwd_pkg::*;

  logic [BYTE_W-1:0] buf_mem [OUT_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  lzwd_emit_e        state_q, state_d;
  logic [OUT_CW-1:0] idx_q, idx_d;
  logic [OUT_CW-1:0] count_q, count_d;
  logic              err_q, err_d;
  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic              flag_q, flag_d;
  logic              slot_free;
  logic              is_last;

  assign slot_free = !valid_q || !out_stall_i;
  assign is_last   = (idx_q == (count_q - 7'd1));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      buf_mem[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
    rdata_q <= buf_mem[idx_q[OUT_AW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      EM_IDLE: begin
        if (ctrl_i.start) state_d = EM_READ;
      end
      EM_READ: state_d = EM_LOAD;
      EM_LOAD: begin
        if (slot_free) state_d = is_last ? EM_IDLE : EM_READ;
      end
      default: state_d = EM_IDLE;
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    count_d = count_q;
    err_d   = err_q;
    valid_d = valid_q && out_stall_i;
    byte_d  = byte_q;
    last_d  = last_q;
    flag_d  = flag_q;
    case (state_q)
      EM_IDLE: begin
        if (ctrl_i.start) begin
          idx_d   = '0;
          count_d = ctrl_i.count;
          err_d   = ctrl_i.err;
        end
      end
      EM_LOAD: begin
        if (slot_free) begin
          valid_d = 1'b1;
          byte_d  = rdata_q;
          last_d  = is_last;
          flag_d  = err_q;
          idx_d   = idx_q + 7'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EM_IDLE;
      valid_q <= 1'b0;
      idx_q   <= '0;
      count_q <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    flag_q <= flag_d;
  end

  assign busy_o        = (state_q != EM_IDLE);
  assign out_valid_o   = valid_q;
  assign byte_out_o    = byte_q;
  assign last_of_run_o = last_q;
  assign error_flag_o  = flag_q;

endmodule

`default_nettype wire

// ----- hdl/lzw_decoder_12bit.sv -----
// top level of the 12-bit lzw decoder
//
// input channel: one byte of the packed code stream per transaction
// (in_valid_i, in_stall_o, byte_in_i). every third byte completes two
// 12-bit codes, high code first. output channel: decoded bytes
// (out_valid_o, out_stall_i, byte_out_o, last_of_run_o, error_flag_o).
// the first and second byte of a group are held in registers.
// the third byte starts decoding: each code walks its dictionary chain
// (one dictionary read per string byte) and reverses the string through
// the stack (one stack read per string byte on the reversal), then both
// strings are emitted one byte at a time from the output buffer. a group
// holds two codes of up to 32 bytes each; the chain walk is paced by the
// single read port of the dictionary memory.
// the block takes no byte while a group is being decoded or emitted.
// the last byte of a group waits in the output register while the
// next byte is taken. a stalled receiver holds the output register
// and halts the emit sequence. reset clears the control state and
// the dictionary fill pointer; the dictionary needs no clearing pass.
`default_nettype none

module lzw_decoder_12bit #(
  parameter int unsigned DICT_ENTRIES   = 4096,
  parameter int unsigned MAX_STRING_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic       last_of_run_o,
  output logic       error_flag_o
);
  import lzwd_pkg::*;

  localparam int unsigned DAW = $clog2(DICT_ENTRIES);
  localparam int unsigned SAW = (MAX_STRING_LEN > 2) ? $clog2(MAX_STRING_LEN) : 1;
  localparam int unsigned NW  = $clog2(MAX_STRING_LEN + 1);
  localparam int unsigned EW  = CODE_W + BYTE_W;

  localparam logic [CODE_W-1:0] NF_LIMIT = CODE_W'(DICT_ENTRIES - 1);
  localparam logic [NW-1:0]     LIM_FULL = NW'(MAX_STRING_LEN);
  localparam logic [NW-1:0]     LIM_TAIL = NW'(MAX_STRING_LEN - 1);

  // dictionary: prefix in the upper bits, character in the lower
  logic [EW-1:0]     dict_mem [DICT_ENTRIES];
  logic [EW-1:0]     dict_rdata_q;
  logic [DAW-1:0]    dict_raddr;
  logic              dict_we;

  logic [BYTE_W-1:0] stack_mem [MAX_STRING_LEN];
  logic [BYTE_W-1:0] stack_rdata_q;
  logic [SAW-1:0]    stack_raddr;
  logic              stack_we;
  logic [BYTE_W-1:0] stack_wdata;

  lzwd_state_e       state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [BYTE_W-1:0] held_first_q, held_first_d;
  logic [BYTE_W-1:0] held_second_q, held_second_d;
  logic [CODE_W-1:0] code2_q, code2_d;
  logic [CODE_W-1:0] cur_code_q, cur_code_d;
  logic              sel_q, sel_d;
  logic [CODE_W-1:0] next_free_q, next_free_d;
  logic [CODE_W-1:0] prev_code_q, prev_code_d;
  logic [BYTE_W-1:0] prev_first_q, prev_first_d;
  logic              started_q, started_d;
  logic              err_q, err_d;
  logic [CODE_W-1:0] walk_c_q, walk_c_d;
  logic [NW-1:0]     n_q, n_d;
  logic              tail_q, tail_d;
  logic [BYTE_W-1:0] first_q, first_d;
  logic [NW-1:0]     cp_left_q, cp_left_d;
  logic              cp_pend_q, cp_pend_d;
  logic [OUT_CW-1:0] out_cnt_q, out_cnt_d;

  lzwd_obuf_ctrl_t   obuf_ctrl;
  logic              obuf_busy;

  logic              in_fire;
  logic              code_known;
  logic              code_beyond;
  logic              code_is_free;
  logic [CODE_W-1:0] walk_start;
  logic              walk_fail;
  logic              walk_lit;
  logic [BYTE_W-1:0] chosen_first;
  logic [CODE_W-1:0] rd_prefix;
  logic [BYTE_W-1:0] rd_char;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_fire      = in_valid_i && !in_stall_o;
  assign code_known   = (cur_code_q < LIT_LIMIT);
  assign code_beyond  = (cur_code_q > next_free_q);
  assign code_is_free = (cur_code_q == next_free_q);
  assign walk_start   = code_is_free ? prev_code_q : cur_code_q;
  assign walk_fail    = (n_q >= (tail_q ? LIM_TAIL : LIM_FULL));
  assign walk_lit     = (walk_c_q < LIT_LIMIT);
  assign chosen_first = tail_q ? prev_first_q : first_q;
  assign rd_prefix    = dict_rdata_q[EW-1:BYTE_W];
  assign rd_char      = dict_rdata_q[BYTE_W-1:0];

  assign dict_raddr   = (state_q == ST_CODE) ? walk_start[DAW-1:0] : rd_prefix[DAW-1:0];
  assign dict_we      = (state_q == ST_UPDATE) && (next_free_q < NF_LIMIT);
  assign stack_raddr  = SAW'(cp_left_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (dict_we) begin
      dict_mem[next_free_q[DAW-1:0]] <= {prev_code_q, chosen_first};
    end
    dict_rdata_q <= dict_mem[dict_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[n_q[SAW-1:0]] <= stack_wdata;
    end
    stack_rdata_q <= stack_mem[stack_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (phase_q == 2'd2)) state_d = ST_CODE;
      end
      ST_CODE: begin
        if (!started_q) begin
          state_d = ST_NEXT;
        end else if ((cur_code_q == PAD_CODE) || code_beyond) begin
          state_d = ST_NEXT;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_fail) begin
          state_d = ST_NEXT;
        end else if (walk_lit) begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        if ((cp_left_q == '0) && !cp_pend_q) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_NEXT;
      ST_NEXT: begin
        if (!sel_q) begin
          state_d = ST_CODE;
        end else if (out_cnt_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!obuf_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    phase_d       = phase_q;
    held_first_d  = held_first_q;
    held_second_d = held_second_q;
    code2_d       = code2_q;
    cur_code_d    = cur_code_q;
    sel_d         = sel_q;
    next_free_d   = next_free_q;
    prev_code_d   = prev_code_q;
    prev_first_d  = prev_first_q;
    started_d     = started_q;
    err_d         = err_q;
    walk_c_d      = walk_c_q;
    n_d           = n_q;
    tail_d        = tail_q;
    first_d       = first_q;
    cp_left_d     = cp_left_q;
    cp_pend_d     = cp_pend_q;
    out_cnt_d     = out_cnt_q;
    stack_we      = 1'b0;
    stack_wdata   = rd_char;
    obuf_ctrl     = '0;
    obuf_ctrl.wr_addr = out_cnt_q[OUT_AW-1:0];
    obuf_ctrl.count   = out_cnt_q;
    obuf_ctrl.err     = err_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (phase_q)
            2'd1: begin
              held_second_d = byte_in_i;
              phase_d       = 2'd2;
            end
            2'd2: begin
              phase_d    = 2'd0;
              cur_code_d = {held_first_q, held_second_q[7:4]};
              code2_d    = {held_second_q[3:0], byte_in_i};
              sel_d      = 1'b0;
              out_cnt_d  = '0;
            end
            default: begin
              held_first_d = byte_in_i;
              phase_d      = 2'd1;
            end
          endcase
        end
      end
      ST_CODE: begin
        if (!started_q) begin
          if (code_known) begin
            obuf_ctrl.wr_en   = 1'b1;
            obuf_ctrl.wr_data = cur_code_q[BYTE_W-1:0];
            out_cnt_d         = out_cnt_q + 7'd1;
            prev_code_d       = cur_code_q;
            prev_first_d      = cur_code_q[BYTE_W-1:0];
            started_d         = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end else if (cur_code_q != PAD_CODE) begin
          if (code_beyond) begin
            err_d = 1'b1;
          end else begin
            walk_c_d = walk_start;
            n_d      = '0;
            tail_d   = code_is_free;
          end
        end
      end
      ST_WALK: begin
        if (walk_fail) begin
          err_d = 1'b1;
        end else if (walk_lit) begin
          stack_we    = 1'b1;
          stack_wdata = walk_c_q[BYTE_W-1:0];
          first_d     = walk_c_q[BYTE_W-1:0];
          cp_left_d   = n_q + 1'b1;
          cp_pend_d   = 1'b0;
        end else begin
          stack_we = 1'b1;
          n_d      = n_q + 1'b1;
          walk_c_d = rd_prefix;
        end
      end
      ST_COPY: begin
        // stack read is registered, so the buffer write follows the read
        if (cp_pend_q) begin
          obuf_ctrl.wr_en   = 1'b1;
          obuf_ctrl.wr_data = stack_rdata_q;
          out_cnt_d         = out_cnt_q + 7'd1;
        end
        if (cp_left_q != '0) begin
          cp_left_d = cp_left_q - 1'b1;
          cp_pend_d = 1'b1;
        end else begin
          cp_pend_d = 1'b0;
        end
      end
      ST_UPDATE: begin
        if (tail_q) begin
          obuf_ctrl.wr_en   = 1'b1;
          obuf_ctrl.wr_data = prev_first_q;
          out_cnt_d         = out_cnt_q + 7'd1;
        end
        if (next_free_q < NF_LIMIT) begin
          next_free_d = next_free_q + 12'd1;
        end
        prev_code_d  = cur_code_q;
        prev_first_d = chosen_first;
      end
      ST_NEXT: begin
        if (!sel_q) begin
          cur_code_d = code2_q;
          sel_d      = 1'b1;
        end else if (out_cnt_q != '0) begin
          obuf_ctrl.start = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= 2'd0;
      held_first_q  <= '0;
      held_second_q <= '0;
      sel_q         <= 1'b0;
      next_free_q   <= LIT_LIMIT;
      prev_code_q   <= '0;
      prev_first_q  <= '0;
      started_q     <= 1'b0;
      err_q         <= 1'b0;
      n_q           <= '0;
      tail_q        <= 1'b0;
      cp_left_q     <= '0;
      cp_pend_q     <= 1'b0;
      out_cnt_q     <= '0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      held_first_q  <= held_first_d;
      held_second_q <= held_second_d;
      sel_q         <= sel_d;
      next_free_q   <= next_free_d;
      prev_code_q   <= prev_code_d;
      prev_first_q  <= prev_first_d;
      started_q     <= started_d;
      err_q         <= err_d;
      n_q           <= n_d;
      tail_q        <= tail_d;
      cp_left_q     <= cp_left_d;
      cp_pend_q     <= cp_pend_d;
      out_cnt_q     <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code2_q    <= code2_d;
    cur_code_q <= cur_code_d;
    walk_c_q   <= walk_c_d;
    first_q    <= first_d;
  end

  lzwd_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (obuf_ctrl),
    .busy_o        (obuf_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_out_o    (byte_out_o),
    .last_of_run_o (last_of_run_o),
    .error_flag_o  (error_flag_o)
  );

  // emit sequencer only runs while the decoder waits for it
  a_emit_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    obuf_busy |-> (state_q == ST_EMIT))
    else $error("emit sequencer busy outside emit state");

  // third byte of a group always starts decoding
  a_group_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (phase_q == 2'd2)) |=> (in_stall_o && (state_q == ST_CODE)))
    else $error("code group did not start decoding");

  // once a valid first code is seen the decoder stays started
  a_started_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");

  // output buffer never overfills
  a_obuf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    obuf_ctrl.wr_en |-> (out_cnt_q < OUT_CW'(OUT_DEPTH)))
    else $error("output buffer overflow");

endmodule

`default_nettype wire
